>>> hw/rtl/assert_macros.svh
// Assertion macros used by the key escape encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tkee_pkg.sv
// Types, codes and sequence-building functions of the key escape encoder.
package tkee_pkg;

   localparam int MAX_TEXT_BYTES = 4;
   localparam int SEQ_BYTES      = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_KITTY  = 2'd0;
   localparam logic [1:0] CSR_APPCUR = 2'd1;

   // Special key codes
   typedef enum logic [4:0] {
      KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT, KEY_HOME, KEY_END,
      KEY_INSERT, KEY_DELETE, KEY_PGUP, KEY_PGDN,
      KEY_F1, KEY_F2, KEY_F3, KEY_F4, KEY_F5, KEY_F6,
      KEY_F7, KEY_F8, KEY_F9, KEY_F10, KEY_F11, KEY_F12,
      KEY_ENTER, KEY_KPENTER, KEY_TAB, KEY_BACKSPACE, KEY_ESCAPE
   } key_type;

   // Characters
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SS3   = 8'h4F;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // Kitty key numbers for the fixed-number keys
   localparam logic [6:0] NUM_ONE = 7'd1;
   localparam logic [6:0] NUM_CR  = 7'd13;
   localparam logic [6:0] NUM_HT  = 7'd9;
   localparam logic [6:0] NUM_DEL = 7'd127;
   localparam logic [6:0] NUM_ESC = 7'd27;

   localparam logic [3:0] MOD_NONE = 4'd1;

   // Byte sequence under construction: count and bytes, byte 0 first
   typedef struct packed {
      logic [3:0]                      n;
      logic [SEQ_BYTES-1:0][7:0]       b;
   } seq_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } cmap_type;

   // Append one byte, drop it when full
   function automatic seq_type seq_put(input seq_type s, input logic [7:0] v);
      seq_type r;
      r = s;
      if (s.n < 4'(SEQ_BYTES)) begin
         r.b[s.n[2:0]] = v;
         r.n = s.n + 4'd1;
      end
      return r;
   endfunction

   // Append a 0..127 value in decimal without leading zeros
   function automatic seq_type seq_dec(input seq_type s, input logic [6:0] v);
      logic       hund;
      logic [6:0] rem;
      logic [3:0] tens;
      logic [6:0] ones;
      seq_type    r;
      hund = (v >= 7'd100);
      rem  = hund ? (v - 7'd100) : v;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (rem >= 7'(10 * k)) tens = tens + 4'd1;
      end
      ones = rem - ({3'b000, tens} * 7'd10);
      r = s;
      if (hund) r = seq_put(r, CH_ONE);
      if (v >= 7'd10) r = seq_put(r, CH_ZERO + {4'h0, tens});
      r = seq_put(r, CH_ZERO + {1'b0, ones});
      return r;
   endfunction

   // ESC [ num [; mod] fin
   function automatic seq_type seq_csi(input seq_type s, input logic [6:0] num,
                                       input logic [3:0] md, input logic [7:0] fin);
      seq_type r;
      r = seq_put(s, CH_ESC);
      r = seq_put(r, CH_LBRK);
      r = seq_dec(r, num);
      if (md != MOD_NONE) begin
         r = seq_put(r, CH_SEMI);
         r = seq_put(r, CH_ZERO + {4'h0, md});
      end
      r = seq_put(r, fin);
      return r;
   endfunction

   // ESC [ 1 ; mod fin when modified, else ESC O fin or ESC [ fin
   function automatic seq_type seq_letter(input seq_type s, input logic [7:0] fin,
                                          input logic [3:0] md, input logic ss3);
      seq_type r;
      r = seq_put(s, CH_ESC);
      if (md != MOD_NONE) begin
         r = seq_put(r, CH_LBRK);
         r = seq_put(r, CH_ONE);
         r = seq_put(r, CH_SEMI);
         r = seq_put(r, CH_ZERO + {4'h0, md});
      end else begin
         r = seq_put(r, ss3 ? CH_SS3 : CH_LBRK);
      end
      r = seq_put(r, fin);
      return r;
   endfunction

   // Ctrl+character to C0 control code
   function automatic cmap_type ctrl_map(input logic [7:0] c);
      cmap_type r;
      r.hit  = 1'b1;
      r.code = 8'h00;
      if (c inside {8'h20, 8'h40}) r.code = 8'h00;
      else if (c inside {[8'h61:8'h7A]}) r.code = c - 8'h60;
      else if (c inside {[8'h41:8'h5F]}) r.code = c - 8'h40;
      else if (c == 8'h2F) r.code = 8'h1F;
      else if (c == 8'h3F) r.code = CH_DEL;
      else r.hit = 1'b0;
      return r;
   endfunction

   // Final character of a cursor, edit or function key
   function automatic logic [7:0] key_final(input logic [4:0] kc);
      logic [7:0] r;
      case (kc)
         KEY_UP:    r = 8'h41;
         KEY_DOWN:  r = 8'h42;
         KEY_RIGHT: r = 8'h43;
         KEY_LEFT:  r = 8'h44;
         KEY_HOME:  r = 8'h48;
         KEY_END:   r = 8'h46;
         KEY_F1:    r = 8'h50;
         KEY_F2:    r = 8'h51;
         KEY_F3:    r = 8'h52;
         KEY_F4:    r = 8'h53;
         default:   r = CH_TILDE;
      endcase
      return r;
   endfunction

   // Tilde number of a key, zero for letter keys
   function automatic logic [6:0] key_tnum(input logic [4:0] kc);
      logic [6:0] r;
      case (kc)
         KEY_INSERT: r = 7'd2;
         KEY_DELETE: r = 7'd3;
         KEY_PGUP:   r = 7'd5;
         KEY_PGDN:   r = 7'd6;
         KEY_F5:     r = 7'd15;
         KEY_F6:     r = 7'd17;
         KEY_F7:     r = 7'd18;
         KEY_F8:     r = 7'd19;
         KEY_F9:     r = 7'd20;
         KEY_F10:    r = 7'd21;
         KEY_F11:    r = 7'd23;
         KEY_F12:    r = 7'd24;
         default:    r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/terminal_key_escape_encoder.sv
// Key event to terminal byte sequence encoder, legacy and kitty forms.
//
//  channel | ports                                   | flow
//  --------+-----------------------------------------+-----------------------------
//  key in  | start, busy, req_*                      | transfer on start && !busy
//  bytes   | rsp_strobe, rsp_out_byte, rsp_last_byte | one byte per strobe, no stall
//  csr     | csr_valid, csr_ready, csr_index, csr_data | transfer on valid && ready
//
// A key is held in the input register, where the whole sequence is built, and then
// loads the output shifter, which drives its bytes onto the byte stream.
// The shifter sends one byte a cycle, so a key of 1 to 8 bytes holds it for its whole
// sequence and a key that yields no bytes loads an empty one; the next key loads on the last byte.
// busy is high while the input register holds a key the shifter cannot take yet.
// Reset clears the valid flag, the shifter count and both configuration registers.
`include "assert_macros.svh"

module terminal_key_escape_encoder (
   input  logic       clock,
   input  logic       reset,
   // key events
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic [4:0] req_key_code,
   input  logic [7:0] req_text_byte0,
   input  logic [7:0] req_text_byte1,
   input  logic [7:0] req_text_byte2,
   input  logic [7:0] req_text_byte3,
   input  logic [2:0] req_text_length,
   input  logic       req_shift_held,
   input  logic       req_alt_held,
   input  logic       req_ctrl_held,
   // byte stream
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic       csr_data
);

   localparam int NB = tkee_pkg::SEQ_BYTES;

   // configuration registers
   logic kitty_ff, kitty_in;
   logic appcur_ff, appcur_in;

   // input register
   logic       a_vld_ff, a_vld_in;
   logic       a_mode_ff;
   logic [4:0] a_kc_ff;
   logic [tkee_pkg::MAX_TEXT_BYTES-1:0][7:0] a_text_ff;
   logic [2:0] a_len_ff;
   logic       a_sh_ff, a_alt_ff, a_ctl_ff;

   // output shifter
   logic [NB-1:0][7:0] sh_bytes_ff, sh_bytes_in;
   logic [3:0]         sh_cnt_ff, sh_cnt_in;

   logic               accept;
   logic               a_take;
   tkee_pkg::seq_type  seq;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      kitty_in  = kitty_ff;
      appcur_in = appcur_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tkee_pkg::CSR_KITTY:  kitty_in  = csr_data;
            tkee_pkg::CSR_APPCUR: appcur_in = csr_data;
            default: ;
         endcase
      end
   end

   // Input handshake: hand the held key to the shifter when it frees up
   assign a_take   = a_vld_ff && (sh_cnt_ff <= 4'd1);
   assign busy     = a_vld_ff && !a_take;
   assign accept   = start && !busy;
   assign a_vld_in = accept ? 1'b1 : (a_take ? 1'b0 : a_vld_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mode_ff <= req_mode;
         a_kc_ff   <= req_key_code;
         a_text_ff <= {req_text_byte3, req_text_byte2, req_text_byte1, req_text_byte0};
         a_len_ff  <= req_text_length;
         a_sh_ff   <= req_shift_held;
         a_alt_ff  <= req_alt_held;
         a_ctl_ff  <= req_ctrl_held;
      end
   end

   // Build the whole sequence for the held key
   always_comb begin
      logic [2:0]         len;
      logic [3:0]         md;
      logic [7:0]         c;
      logic [6:0]         cp;
      tkee_pkg::cmap_type cm;
      len = a_len_ff;
      if (len == 3'd0) len = 3'd1;
      if (len > 3'(tkee_pkg::MAX_TEXT_BYTES)) len = 3'(tkee_pkg::MAX_TEXT_BYTES);
      md  = 4'd1 + {3'b000, a_sh_ff} + {2'b00, a_alt_ff, 1'b0} + {1'b0, a_ctl_ff, 2'b00};
      c   = a_text_ff[0];
      cp  = c[6:0];
      cm  = tkee_pkg::ctrl_map(c);
      seq = '0;
      if (!a_mode_ff) begin
         if (kitty_ff && len == 3'd1 && (a_ctl_ff || a_alt_ff) && !c[7]) begin
            // kitty CSI u for a modified ASCII key, letters folded to lower case
            if (a_ctl_ff && c inside {[8'h01:8'h1A]}) cp = c[6:0] + 7'h60;
            else if (c inside {[8'h41:8'h5A]}) cp = c[6:0] + 7'h20;
            seq = tkee_pkg::seq_csi(seq, cp, md, tkee_pkg::CH_U);
         end else begin
            if (a_alt_ff) seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_ESC);
            if (a_ctl_ff && len == 3'd1 && cm.hit) begin
               seq = tkee_pkg::seq_put(seq, cm.code);
            end else begin
               for (int i = 0; i < tkee_pkg::MAX_TEXT_BYTES; i++) begin
                  if (3'(i) < len) seq = tkee_pkg::seq_put(seq, a_text_ff[i]);
               end
            end
         end
      end else if (a_kc_ff <= tkee_pkg::KEY_ESCAPE) begin
         if (kitty_ff) begin
            if (a_kc_ff < tkee_pkg::KEY_ENTER) begin
               if (a_kc_ff == tkee_pkg::KEY_F3)
                  seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_CR, md, tkee_pkg::CH_TILDE);
               else if (tkee_pkg::key_tnum(a_kc_ff) != 7'd0)
                  seq = tkee_pkg::seq_csi(seq, tkee_pkg::key_tnum(a_kc_ff), md,
                                          tkee_pkg::CH_TILDE);
               else
                  seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_ONE, md,
                                          tkee_pkg::key_final(a_kc_ff));
            end else if (a_kc_ff == tkee_pkg::KEY_ENTER || a_kc_ff == tkee_pkg::KEY_KPENTER) begin
               seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_CR, md, tkee_pkg::CH_U);
            end else if (a_kc_ff == tkee_pkg::KEY_TAB) begin
               seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_HT, md, tkee_pkg::CH_U);
            end else if (a_kc_ff == tkee_pkg::KEY_BACKSPACE) begin
               seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_DEL, md, tkee_pkg::CH_U);
            end else begin
               seq = tkee_pkg::seq_csi(seq, tkee_pkg::NUM_ESC, md, tkee_pkg::CH_U);
            end
         end else if (a_kc_ff < tkee_pkg::KEY_ENTER) begin
            // legacy cursor, edit and function keys
            if (tkee_pkg::key_tnum(a_kc_ff) != 7'd0)
               seq = tkee_pkg::seq_csi(seq, tkee_pkg::key_tnum(a_kc_ff), md,
                                       tkee_pkg::CH_TILDE);
            else
               seq = tkee_pkg::seq_letter(seq, tkee_pkg::key_final(a_kc_ff), md,
                                          (a_kc_ff >= tkee_pkg::KEY_F1) || appcur_ff);
         end else if (a_kc_ff == tkee_pkg::KEY_TAB && a_sh_ff) begin
            // back-tab
            seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_ESC);
            seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_LBRK);
            seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_Z);
         end else begin
            if (a_alt_ff) seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_ESC);
            if (a_kc_ff == tkee_pkg::KEY_ENTER || a_kc_ff == tkee_pkg::KEY_KPENTER)
               seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_CR);
            else if (a_kc_ff == tkee_pkg::KEY_TAB)
               seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_HT);
            else if (a_kc_ff == tkee_pkg::KEY_BACKSPACE)
               seq = tkee_pkg::seq_put(seq, a_ctl_ff ? tkee_pkg::CH_BS : tkee_pkg::CH_DEL);
            else
               seq = tkee_pkg::seq_put(seq, tkee_pkg::CH_ESC);
         end
      end
   end

   // Shifter: load a new sequence, else advance one byte
   always_comb begin
      sh_bytes_in = sh_bytes_ff;
      sh_cnt_in   = sh_cnt_ff;
      if (a_take) begin
         sh_bytes_in = seq.b;
         sh_cnt_in   = seq.n;
      end else if (sh_cnt_ff != 4'd0) begin
         sh_bytes_in = {8'h00, sh_bytes_ff[NB-1:1]};
         sh_cnt_in   = sh_cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      sh_bytes_ff <= sh_bytes_in;
      if (reset) begin
         kitty_ff  <= 1'b0;
         appcur_ff <= 1'b0;
         a_vld_ff  <= 1'b0;
         sh_cnt_ff <= 4'd0;
      end else begin
         kitty_ff  <= kitty_in;
         appcur_ff <= appcur_in;
         a_vld_ff  <= a_vld_in;
         sh_cnt_ff <= sh_cnt_in;
      end
   end

   // Drive the byte stream straight from the shifter head
   assign rsp_strobe    = (sh_cnt_ff != 4'd0);
   assign rsp_out_byte  = sh_bytes_ff[0];
   assign rsp_last_byte = (sh_cnt_ff == 4'd1);

   `ASSERT_NEXT(a_mid_seq_no_reload, rsp_strobe && !rsp_last_byte,
                rsp_strobe && (sh_cnt_ff == $past(sh_cnt_ff) - 4'd1),
                "shifter reloaded or stalled in the middle of a sequence")
   `ASSERT_NEXT(a_held_key_kept, a_vld_ff && !a_take, a_vld_ff,
                "held key dropped before the shifter took it")
   `ASSERT_IMPL(a_text_nonempty, a_vld_ff && !a_mode_ff,
                (seq.n != 4'd0) && (seq.n <= 4'(NB)),
                "text key built an empty or oversized sequence")

endmodule
